/* rtl/core/crc32tic_pkg.sv */
// shared types, constants and crc function for the crc32 trailer integrity checker
`default_nettype none

package crc32tic_pkg;

  localparam int unsigned TRAILER_BYTES = 24;
  localparam int unsigned WIN_W         = TRAILER_BYTES * 8;
  localparam int unsigned CNT_W         = $clog2(TRAILER_BYTES + 1);
  localparam int unsigned OUT_TDATA_W   = 40;

  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES      = 32'hFFFF_FFFF;
  localparam logic [31:0] TRAILER_MAGIC = 32'h4352_4332;

  // trailer byte offsets, little endian words
  localparam int unsigned OFF_ADDR     = TRAILER_BYTES - 24;
  localparam int unsigned OFF_SIZE     = TRAILER_BYTES - 16;
  localparam int unsigned OFF_REGION   = TRAILER_BYTES - 12;
  localparam int unsigned OFF_PAYLOAD  = TRAILER_BYTES - 8;
  localparam int unsigned OFF_MAGIC    = TRAILER_BYTES - 4;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TRAILER_BYTES);

  typedef enum logic [2:0] {
    CAUSE_TOO_SHORT    = 3'd0,
    CAUSE_NO_MAGIC     = 3'd1,
    CAUSE_PAYLOAD_BAD  = 3'd2,
    CAUSE_REGION_BAD   = 3'd3,
    CAUSE_ALL_OK       = 3'd4,
    CAUSE_OK_NO_REGION = 3'd5
  } cause_e;

  typedef enum logic [1:0] {
    PHASE_BUFFER = 2'd0,
    PHASE_REGION = 2'd1
  } phase_e;

  typedef enum logic {
    SRC_BUFFER = 1'b0,
    SRC_REGION = 1'b1
  } source_e;

  typedef logic [WIN_W-1:0] window_t;

  typedef struct packed {
    source_e    source;
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic        accept;
    cause_e      cause;
    logic [31:0] computed_crc;
  } result_t;

  // reflected crc-32, one byte, bitwise
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/crc32_trailer_integrity_checker_core.sv */
// top level of the crc32 trailer integrity checker
// usage:
//   s_axis carries one byte per request: tdata = data byte, tuser = source
//   (0 buffer, 1 region), tlast = final byte of the buffer (ignored for region)
//   the last 24 buffer bytes are the trailer; bytes leaving the 24-byte window
//   feed a reflected crc-32. at the buffer's last byte the block decides, or,
//   if the trailer names a region, waits for that many region bytes first
//   m_axis carries a decision: tdata[0] accept, [3:1] cause, [35:4] crc
//   throughput: one byte per cycle unless m_axis stalls, set by the single crc
//   byte unit and the window shift between the input and result registers
//   a decision goes from the input register through the engine into the result
//   register and is held on m_axis until the receiver takes it
//   bytes that cause no decision produce nothing on m_axis
//   when m_axis stalls, the engine holds while a decision is pending, the
//   input register fills and then s_axis_tready drops
//   reset clears both stage valids, the fill count, the crc and the phase;
//   the block is ready for a new buffer as soon as reset is released
`default_nettype none

module crc32_trailer_integrity_checker_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire         s_axis_tuser,   // [0] source
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata    // [0] accept, [3:1] cause, [35:4] computed_crc, [39:36] 0
);

  crc32tic_pkg::item_t   in_item, stage_item;
  crc32tic_pkg::result_t eng_res, out_res;
  logic                  stage_valid;
  logic                  fire;
  logic                  res_valid;

  assign in_item.source    = crc32tic_pkg::source_e'(s_axis_tuser);
  assign in_item.data_byte = s_axis_tdata;
  assign in_item.last      = s_axis_tlast;

  // engine advances whenever the result slot is free or being emptied
  assign fire = stage_valid && (!m_axis_tvalid || m_axis_tready);

  crc32tic_in_stage u_in_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tvalid_i (s_axis_tvalid),
    .tready_o (s_axis_tready),
    .item_i   (in_item),
    .fire_i   (fire),
    .valid_o  (stage_valid),
    .item_o   (stage_item)
  );

  crc32tic_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (stage_item),
    .res_valid_o (res_valid),
    .res_o       (eng_res)
  );

  crc32tic_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (res_valid),
    .res_i    (eng_res),
    .tready_i (m_axis_tready),
    .tvalid_o (m_axis_tvalid),
    .res_o    (out_res)
  );

  assign m_axis_tdata = {4'd0, out_res.computed_crc, out_res.cause, out_res.accept};

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!m_axis_tvalid || m_axis_tready))
    else $error("decision would overwrite a pending result");

endmodule

`default_nettype wire

/* rtl/core/crc32tic_in_stage.sv */
// input register stage holding one request for the check engine
`default_nettype none

module crc32tic_in_stage (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 tvalid_i,
  output logic                tready_o,
  input  crc32tic_pkg::item_t item_i,
  input  wire                 fire_i,
  output logic                valid_o,
  output crc32tic_pkg::item_t item_o
);

  logic                valid_q, valid_d;
  crc32tic_pkg::item_t item_q;
  logic                take;

  assign tready_o = !valid_q || fire_i;
  assign take     = tvalid_i && tready_o;
  assign valid_d  = take || (valid_q && !fire_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

/* rtl/core/crc32tic_engine.sv */
// trailer window, running crc and decision logic, one byte per cycle while fire_i is high
`default_nettype none

module crc32tic_engine (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   fire_i,
  input  crc32tic_pkg::item_t   item_i,
  output logic                  res_valid_o,
  output crc32tic_pkg::result_t res_o
);

  crc32tic_pkg::window_t            win_q, win_d;
  logic [crc32tic_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [31:0]                      crc_q, crc_d;
  crc32tic_pkg::phase_e             phase_q, phase_d;
  logic [31:0]                      rem_q, rem_d;
  logic [31:0]                      exp_q, exp_d;

  logic        full;
  logic [7:0]  crc_in_byte;
  logic [31:0] crc_new;
  logic [31:0] crc_fin;
  logic [31:0] w_magic, w_payload, w_region, w_size;
  logic        addr_zero;
  logic [31:0] pay_fin;

  assign full        = (cnt_q == crc32tic_pkg::CNT_FULL);
  // one crc unit: region byte in region phase, oldest window byte otherwise
  assign crc_in_byte = (phase_q == crc32tic_pkg::PHASE_REGION) ? item_i.data_byte : win_q[7:0];
  assign crc_new     = crc32tic_pkg::crc_byte(crc_q, crc_in_byte);
  assign crc_fin     = crc_new ^ crc32tic_pkg::CRC_ONES;

  always_comb begin
    if (full) begin
      win_d = {item_i.data_byte, win_q[crc32tic_pkg::WIN_W-1:8]};
    end else begin
      win_d = win_q;
      for (int i = 0; i < crc32tic_pkg::TRAILER_BYTES; i++) begin
        if (cnt_q == crc32tic_pkg::CNT_W'(i)) begin
          win_d[i*8 +: 8] = item_i.data_byte;
        end
      end
    end
  end

  assign w_magic   = win_d[crc32tic_pkg::OFF_MAGIC*8   +: 32];
  assign w_payload = win_d[crc32tic_pkg::OFF_PAYLOAD*8 +: 32];
  assign w_region  = win_d[crc32tic_pkg::OFF_REGION*8  +: 32];
  assign w_size    = win_d[crc32tic_pkg::OFF_SIZE*8    +: 32];
  assign addr_zero = (win_d[crc32tic_pkg::OFF_ADDR*8 +: 64] == 64'd0);

  assign pay_fin = (full ? crc_new : crc_q) ^ crc32tic_pkg::CRC_ONES;

  always_comb begin
    logic emit;
    emit         = 1'b0;
    cnt_d        = cnt_q;
    crc_d        = crc_q;
    phase_d      = phase_q;
    rem_d        = rem_q;
    exp_d        = exp_q;
    res_o        = '0;
    if (fire_i) begin
      if (phase_q == crc32tic_pkg::PHASE_REGION) begin
        if (item_i.source == crc32tic_pkg::SRC_REGION) begin
          crc_d = crc_new;
          rem_d = rem_q - 32'd1;
          if (rem_q == 32'd1) begin
            emit               = 1'b1;
            res_o.computed_crc = crc_fin;
            if (crc_fin != exp_q) begin
              res_o.accept = 1'b0;
              res_o.cause  = crc32tic_pkg::CAUSE_REGION_BAD;
            end else begin
              res_o.accept = 1'b1;
              res_o.cause  = crc32tic_pkg::CAUSE_ALL_OK;
            end
          end
        end
      end else if (item_i.source == crc32tic_pkg::SRC_BUFFER) begin
        if (full) begin
          crc_d = crc_new;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
        if (item_i.last) begin
          priority if (cnt_d != crc32tic_pkg::CNT_FULL) begin
            emit         = 1'b1;
            res_o.accept = 1'b1;
            res_o.cause  = crc32tic_pkg::CAUSE_TOO_SHORT;
          end else if (w_magic != crc32tic_pkg::TRAILER_MAGIC) begin
            emit         = 1'b1;
            res_o.accept = 1'b1;
            res_o.cause  = crc32tic_pkg::CAUSE_NO_MAGIC;
          end else if (pay_fin != w_payload) begin
            emit               = 1'b1;
            res_o.accept       = 1'b0;
            res_o.cause        = crc32tic_pkg::CAUSE_PAYLOAD_BAD;
            res_o.computed_crc = pay_fin;
          end else if (addr_zero || (w_size == 32'd0)) begin
            emit               = 1'b1;
            res_o.accept       = 1'b1;
            res_o.cause        = crc32tic_pkg::CAUSE_OK_NO_REGION;
            res_o.computed_crc = pay_fin;
          end else begin
            cnt_d   = '0;
            crc_d   = crc32tic_pkg::CRC_ONES;
            phase_d = crc32tic_pkg::PHASE_REGION;
            rem_d   = w_size;
            exp_d   = w_region;
          end
        end
      end
    end
    if (emit) begin
      cnt_d   = '0;
      crc_d   = crc32tic_pkg::CRC_ONES;
      phase_d = crc32tic_pkg::PHASE_BUFFER;
    end
    res_valid_o = emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      crc_q   <= crc32tic_pkg::CRC_ONES;
      phase_q <= crc32tic_pkg::PHASE_BUFFER;
      rem_q   <= '0;
      exp_q   <= '0;
    end else begin
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      phase_q <= phase_d;
      rem_q   <= rem_d;
      exp_q   <= exp_d;
    end
  end

  // window bytes are only read once the fill count covers them
  always_ff @(posedge clk_i) begin
    if (fire_i && (phase_q == crc32tic_pkg::PHASE_BUFFER) &&
        (item_i.source == crc32tic_pkg::SRC_BUFFER)) begin
      win_q <= win_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= crc32tic_pkg::CNT_FULL)
    else $error("window fill count past trailer size");

  a_region_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == crc32tic_pkg::PHASE_REGION) |-> (rem_q != 32'd0) && (cnt_q == '0))
    else $error("region phase with nothing left to take");

  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (cnt_q == '0) && (crc_q == crc32tic_pkg::CRC_ONES) &&
                    (phase_q == crc32tic_pkg::PHASE_BUFFER))
    else $error("buffer state not cleared after a decision");

  a_result_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> fire_i)
    else $error("result without a request");

endmodule

`default_nettype wire

/* rtl/core/crc32tic_out_stage.sv */
// result register holding one decision until the receiver takes it
`default_nettype none

module crc32tic_out_stage (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   load_i,
  input  crc32tic_pkg::result_t res_i,
  input  wire                   tready_i,
  output logic                  tvalid_o,
  output crc32tic_pkg::result_t res_o
);

  logic                  valid_q, valid_d;
  crc32tic_pkg::result_t res_q;

  assign valid_d = load_i || (valid_q && !tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign tvalid_o = valid_q;
  assign res_o    = res_q;

endmodule

`default_nettype wire

/* verif/crc32_trailer_integrity_checker_core_tb.sv */
// self-checking testbench for the crc32 trailer integrity checker core
module crc32_trailer_integrity_checker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS   = 10;
  localparam int TAIL_CYCLES   = 8;
  localparam int RANDOM_BYTES  = 430;
  localparam int MAX_REGION_Q  = 512;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tuser;   // [0] source
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [0] accept, [3:1] cause, [35:4] computed_crc, [39:36] 0

  crc32_trailer_integrity_checker_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // checker state mirror
  logic [7:0]            trail [crc32tic_pkg::TRAILER_BYTES];
  int unsigned           trail_fill;
  logic [31:0]           crc_acc;
  crc32tic_pkg::phase_e  chk_phase;
  logic [31:0]           region_left;
  logic [31:0]           region_want;
  crc32tic_pkg::result_t decision_q[$];

  logic [7:0]  frame_q[$];
  logic [7:0]  region_q[$];

  int src_idle_pct;
  int snk_idle_pct;
  int rx_hold_left;
  int bytes_taken;
  int strays_taken;
  int decisions_seen;
  int mismatches;
  int cause_hits [6];
  crc32tic_pkg::result_t want_dec;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("crc32_trailer_integrity_checker_core regression: fail");
    $finish;
  end

  function automatic logic [31:0] crc32_fold(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] v;
    v = acc ^ {24'd0, b};
    repeat (8) v = v[0] ? ((v >> 1) ^ crc32tic_pkg::CRC_POLY) : (v >> 1);
    return v;
  endfunction

  function automatic logic [31:0] trail_word(input int off);
    return {trail[off+3], trail[off+2], trail[off+1], trail[off]};
  endfunction

  // finished crc over the whole region or frame scratch queue
  function automatic logic [31:0] crc_of(input bit region);
    logic [31:0] acc;
    acc = crc32tic_pkg::CRC_ONES;
    if (region) begin
      foreach (region_q[i]) acc = crc32_fold(acc, region_q[i]);
    end else begin
      foreach (frame_q[i]) acc = crc32_fold(acc, frame_q[i]);
    end
    return acc ^ crc32tic_pkg::CRC_ONES;
  endfunction

  task automatic reset_window();
    for (int i = 0; i < crc32tic_pkg::TRAILER_BYTES; i++) trail[i] = 8'd0;
    trail_fill = 0;
    crc_acc    = crc32tic_pkg::CRC_ONES;
    chk_phase  = crc32tic_pkg::PHASE_BUFFER;
  endtask

  task automatic post_decision(input logic acc, input crc32tic_pkg::cause_e c,
                               input logic [31:0] v);
    crc32tic_pkg::result_t r;
    r.accept       = acc;
    r.cause        = c;
    r.computed_crc = v;
    decision_q.push_back(r);
    reset_window();
  endtask

  task automatic decide_trailer();
    logic [31:0] pay;
    if (trail_fill < crc32tic_pkg::TRAILER_BYTES) begin
      post_decision(1'b1, crc32tic_pkg::CAUSE_TOO_SHORT, 32'd0);
    end else if (trail_word(crc32tic_pkg::OFF_MAGIC) != crc32tic_pkg::TRAILER_MAGIC) begin
      post_decision(1'b1, crc32tic_pkg::CAUSE_NO_MAGIC, 32'd0);
    end else begin
      pay = crc_acc ^ crc32tic_pkg::CRC_ONES;
      if (pay != trail_word(crc32tic_pkg::OFF_PAYLOAD)) begin
        post_decision(1'b0, crc32tic_pkg::CAUSE_PAYLOAD_BAD, pay);
      end else if ((trail_word(crc32tic_pkg::OFF_ADDR) |
                    trail_word(crc32tic_pkg::OFF_ADDR + 4)) == 32'd0 ||
                   trail_word(crc32tic_pkg::OFF_SIZE) == 32'd0) begin
        post_decision(1'b1, crc32tic_pkg::CAUSE_OK_NO_REGION, pay);
      end else begin
        region_left = trail_word(crc32tic_pkg::OFF_SIZE);
        region_want = trail_word(crc32tic_pkg::OFF_REGION);
        reset_window();
        chk_phase = crc32tic_pkg::PHASE_REGION;
      end
    end
  endtask

  task automatic model_byte(input crc32tic_pkg::source_e src, input logic [7:0] b,
                            input logic lst, output bit ignored);
    logic [31:0] fin;
    ignored = 1'b0;
    if (chk_phase == crc32tic_pkg::PHASE_REGION) begin
      if (src != crc32tic_pkg::SRC_REGION) begin
        ignored = 1'b1;
      end else begin
        crc_acc     = crc32_fold(crc_acc, b);
        region_left = region_left - 32'd1;
        if (region_left == 32'd0) begin
          fin = crc_acc ^ crc32tic_pkg::CRC_ONES;
          if (fin != region_want) post_decision(1'b0, crc32tic_pkg::CAUSE_REGION_BAD, fin);
          else post_decision(1'b1, crc32tic_pkg::CAUSE_ALL_OK, fin);
        end
      end
    end else if (src != crc32tic_pkg::SRC_BUFFER) begin
      ignored = 1'b1;
    end else begin
      if (trail_fill < crc32tic_pkg::TRAILER_BYTES) begin
        trail[trail_fill] = b;
        trail_fill++;
      end else begin
        // oldest window byte leaves into the payload crc
        crc_acc = crc32_fold(crc_acc, trail[0]);
        for (int i = 0; i < crc32tic_pkg::TRAILER_BYTES - 1; i++) trail[i] = trail[i+1];
        trail[crc32tic_pkg::TRAILER_BYTES-1] = b;
      end
      if (lst) decide_trailer();
    end
  endtask

  // called and returns at a falling edge
  task automatic send_byte(input crc32tic_pkg::source_e src, input logic [7:0] b,
                           input logic lst);
    bit ign;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= src;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    model_byte(src, b, lst, ign);
    if (ign) strays_taken++;
    else bytes_taken++;
    @(negedge clk_i);
  endtask

  task automatic drain_decisions();
    s_axis_tvalid <= 1'b0;
    while (decision_q.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic push_le(input logic [31:0] w);
    for (int k = 0; k < 4; k++) frame_q.push_back(w[8*k +: 8]);
  endtask

  task automatic build_frame(input int pay_len, input logic [63:0] addr,
                             input logic [31:0] size, input logic [31:0] reg_crc,
                             input bit pay_ok, input logic [31:0] magic);
    logic [31:0] pc;
    frame_q.delete();
    repeat (pay_len) frame_q.push_back(8'($urandom));
    pc = crc_of(1'b0);
    if (!pay_ok) pc ^= 32'h1 << $urandom_range(31);
    push_le(addr[31:0]);
    push_le(addr[63:32]);
    push_le(size);
    push_le(reg_crc);
    push_le(pc);
    push_le(magic);
  endtask

  // stray region bytes are slipped in ahead of buffer bytes, the block ignores them
  task automatic send_frame(input int stray_pct);
    foreach (frame_q[i]) begin
      if ($urandom_range(99) < stray_pct)
        send_byte(crc32tic_pkg::SRC_REGION, 8'($urandom), 1'($urandom));
      send_byte(crc32tic_pkg::SRC_BUFFER, frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  task automatic send_region(input int stray_pct);
    foreach (region_q[i]) begin
      if ($urandom_range(99) < stray_pct)
        send_byte(crc32tic_pkg::SRC_BUFFER, 8'($urandom), 1'($urandom));
      send_byte(crc32tic_pkg::SRC_REGION, region_q[i], 1'($urandom));
    end
  endtask

  task automatic run_raw(input int len, input int stray_pct);
    frame_q.delete();
    repeat (len) frame_q.push_back(8'($urandom));
    send_frame(stray_pct);
  endtask

  task automatic run_protected(input int pay_len, input logic [63:0] addr,
                               input logic [31:0] size, input bit region_ok,
                               input bit pay_ok, input logic [31:0] magic,
                               input int stray_pct);
    logic [31:0] rc;
    region_q.delete();
    if (size <= MAX_REGION_Q) repeat (size) region_q.push_back(8'($urandom));
    rc = crc_of(1'b1);
    if (!region_ok) rc ^= 32'h1 << $urandom_range(31);
    build_frame(pay_len, addr, size, rc, pay_ok, magic);
    send_frame(stray_pct);
    if (chk_phase == crc32tic_pkg::PHASE_REGION) send_region(stray_pct);
  endtask

  task automatic test_short_buffers();
    send_byte(crc32tic_pkg::SRC_BUFFER, 8'h00, 1'b1);
    send_byte(crc32tic_pkg::SRC_BUFFER, 8'hFF, 1'b1);
    run_raw(crc32tic_pkg::TRAILER_BYTES - 1, 0);
  endtask

  task automatic test_missing_magic();
    run_protected(0, 64'h1, 4, 1'b1, 1'b1,
                  crc32tic_pkg::TRAILER_MAGIC ^ (32'h1 << $urandom_range(31)), 0);
    run_raw(40, 0);
  endtask

  task automatic test_payload_check();
    // bare trailer, empty payload has crc zero
    run_protected(0, 64'd0, 0, 1'b1, 1'b1, crc32tic_pkg::TRAILER_MAGIC, 0);
    run_protected(16, {$urandom, $urandom}, 5, 1'b1, 1'b0, crc32tic_pkg::TRAILER_MAGIC, 0);
    run_protected(2, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0,
                  crc32tic_pkg::TRAILER_MAGIC, 0);
  endtask

  task automatic test_region_check();
    run_protected(8, {$urandom, $urandom} | 64'h1, 6, 1'b1, 1'b1,
                  crc32tic_pkg::TRAILER_MAGIC, 0);
    run_protected(3, 64'h1 << 40, 6, 1'b0, 1'b1, crc32tic_pkg::TRAILER_MAGIC, 0);
    run_protected(5, 64'd0, 9, 1'b1, 1'b1, crc32tic_pkg::TRAILER_MAGIC, 0);
    run_protected(5, 64'h1 << 63, 0, 1'b1, 1'b1, crc32tic_pkg::TRAILER_MAGIC, 0);
    run_protected(0, 64'h1, 1, 1'b1, 1'b1, crc32tic_pkg::TRAILER_MAGIC, 0);
  endtask

  task automatic test_stray_bytes();
    send_byte(crc32tic_pkg::SRC_REGION, 8'hFF, 1'b1);
    run_protected(4, 64'h8000_0000, 10, 1'b1, 1'b1, crc32tic_pkg::TRAILER_MAGIC, 50);
  endtask

  // receiver stalls long enough for results to back up into the input
  task automatic test_backpressure();
    rx_hold_left = 300;
    repeat (12) run_raw(1, 0);
    drain_decisions();
  endtask

  task automatic test_random(input int src_pct, input int snk_pct, input int n);
    int          goal;
    int          pick;
    int          pay_len;
    logic [31:0] sz;
    logic [63:0] addr;
    bit          pay_ok;
    bit          reg_ok;
    logic [31:0] magic;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    goal = bytes_taken + n;
    while (bytes_taken < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        pay_len = ($urandom_range(19) == 0) ? $urandom_range(300, 100) : $urandom_range(40);
        case ($urandom_range(3))
          0:       addr = 64'd0;
          1:       addr = 64'h1 << $urandom_range(63);
          default: addr = {$urandom, $urandom};
        endcase
        case ($urandom_range(9))
          0:       sz = 32'd0;
          1:       sz = $urandom_range(300, 60);
          default: sz = $urandom_range(16, 1);
        endcase
        pay_ok = $urandom_range(9) != 0;
        if (!pay_ok && $urandom_range(1)) sz = $urandom;
        reg_ok = $urandom_range(3) != 0;
        magic = ($urandom_range(15) == 0) ?
                crc32tic_pkg::TRAILER_MAGIC ^ (32'h1 << $urandom_range(31)) :
                crc32tic_pkg::TRAILER_MAGIC;
        run_protected(pay_len, addr, sz, reg_ok, pay_ok, magic,
                      ($urandom_range(3) == 0) ? 10 : 0);
      end else if (pick < 90) begin
        run_raw($urandom_range(48, 1), 0);
      end else begin
        repeat ($urandom_range(4, 1))
          send_byte(crc32tic_pkg::SRC_REGION, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic flag_error(input string what, input logic [31:0] exp_v,
                            input logic [31:0] got_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %h got %h", $time, what, exp_v, got_v);
  endtask

  // receiver ready, with a counted hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (decision_q.size() == 0) begin
        flag_error("unexpected decision", 32'd0, m_axis_tdata[31:0]);
      end else begin
        want_dec = decision_q.pop_front();
        decisions_seen++;
        cause_hits[want_dec.cause]++;
        if (m_axis_tdata[0] !== want_dec.accept)
          flag_error("accept", 32'(want_dec.accept), 32'(m_axis_tdata[0]));
        if (m_axis_tdata[3:1] !== want_dec.cause)
          flag_error("cause", 32'(want_dec.cause), 32'(m_axis_tdata[3:1]));
        if (m_axis_tdata[35:4] !== want_dec.computed_crc)
          flag_error("computed_crc", want_dec.computed_crc, m_axis_tdata[35:4]);
        if (m_axis_tdata[39:36] !== 4'd0)
          flag_error("pad bits", 32'd0, 32'(m_axis_tdata[39:36]));
      end
    end
  end

  initial begin
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = 8'd0;
    s_axis_tuser   = 1'b0;
    s_axis_tlast   = 1'b0;
    rst_ni         = 1'b0;
    src_idle_pct   = 0;
    snk_idle_pct   = 0;
    rx_hold_left   = 0;
    bytes_taken    = 0;
    strays_taken   = 0;
    decisions_seen = 0;
    mismatches     = 0;
    foreach (cause_hits[i]) cause_hits[i] = 0;
    region_left    = 32'd0;
    region_want    = 32'd0;
    reset_window();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    src_idle_pct = 20;
    snk_idle_pct = 20;
    test_short_buffers();
    test_missing_magic();
    test_payload_check();
    test_region_check();
    test_stray_bytes();
    test_backpressure();
    test_random(7, 87, RANDOM_BYTES);
    test_random(87, 7, RANDOM_BYTES);
    test_random(0, 0, RANDOM_BYTES);

    drain_decisions();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (decision_q.size() != 0)
      flag_error("decisions never delivered", 32'd0, 32'(decision_q.size()));

    $display("covered %0d checked bytes plus %0d ignored strays, %0d decisions",
             bytes_taken, strays_taken, decisions_seen);
    $display("by cause: short %0d, no magic %0d, payload bad %0d,",
             cause_hits[crc32tic_pkg::CAUSE_TOO_SHORT],
             cause_hits[crc32tic_pkg::CAUSE_NO_MAGIC],
             cause_hits[crc32tic_pkg::CAUSE_PAYLOAD_BAD]);
    $display("  region bad %0d, ok %0d, ok no region %0d",
             cause_hits[crc32tic_pkg::CAUSE_REGION_BAD],
             cause_hits[crc32tic_pkg::CAUSE_ALL_OK],
             cause_hits[crc32tic_pkg::CAUSE_OK_NO_REGION]);
    if (mismatches == 0) begin
      $display("crc32_trailer_integrity_checker_core regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("crc32_trailer_integrity_checker_core regression: fail");
    end
    $finish;
  end

endmodule
